>>> rtl/gb3_pkg.sv
// Shared types and constants of the 3x3 Gaussian blur stream core.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package gb3_pkg;

  // pixel word width and the fixed field widths of the queue entry and the configuration port
  localparam int PIX_W   = 16;
  localparam int ROW_W   = 16;
  localparam int COL_FW  = 16;   // column as carried in the queue, covers any line length
  localparam int WCFG_W  = 13;
  localparam int HCFG_W  = 16;
  localparam int CFG_DW  = 16;
  localparam int CFG_IW  = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;

  // weighted sum and the divide by 36 (shift by two, then reciprocal of nine)
  localparam int NUM_W   = PIX_W + 6;
  localparam int QIN_W   = NUM_W - 2;
  localparam int DIV9_K  = QIN_W + 6;
  localparam int DIV9_MW = DIV9_K - 3;
  localparam int PROD_W  = QIN_W + DIV9_MW;
  localparam logic [DIV9_MW-1:0] DIV9_M = DIV9_MW'(((64'd1 << DIV9_K) + 64'd8) / 64'd9);
  localparam logic [NUM_W-1:0]   ROUND_BIAS = NUM_W'(18);

  // result slots that one pixel can cause, in emission order
  localparam int RES_INNER = 0;  // (c-1, r-1), filtered or border
  localparam int RES_RIGHT = 1;  // (c, r-1), last column
  localparam int RES_BELOW = 2;  // (c-1, r), last row
  localparam int RES_LAST  = 3;  // (c, r), final pixel of the image
  localparam int NRES      = 4;

  typedef struct packed {
    logic [WCFG_W-1:0] width;
    logic [HCFG_W-1:0] height;
  } cfg_t;

  // one queue entry: position of the causing pixel, which results it makes and their values
  typedef struct packed {
    logic [COL_FW-1:0] col;
    logic [ROW_W-1:0]  row;
    logic [NRES-1:0]   emit;
    logic [PIX_W-1:0]  v_inner;
    logic [PIX_W-1:0]  v_right;
    logic [PIX_W-1:0]  v_below;
    logic [PIX_W-1:0]  v_last;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/gb3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read-first on a same-address collision; the output holds while no read is issued.
`default_nettype none

module gb3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/gb3_front.sv
// Front end: takes pixels, tracks position, keeps the two line stores and the window,
// and classifies each pixel into the results it causes. Uses gb3_pkg and gb3_ram.
`default_nettype none

module gb3_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire gb3_pkg::cfg_t          cfg,
  input  wire logic                   pixel_valid,
  output logic                        pixel_stall,
  input  wire logic [gb3_pkg::PIX_W-1:0] pixel,
  input  wire logic                   frame_start,
  output logic                        push,
  output gb3_pkg::entry_t             push_entry,
  input  wire logic                   full
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = gb3_pkg::PIX_W;
  localparam int LW = 17;
  localparam logic [LW-1:0] MAXW = LW'(MAX_WIDTH);

  // position of the next pixel
  logic [CW-1:0]             col_count;
  logic [gb3_pkg::ROW_W-1:0] row_count;

  // stage 1: line store data valid
  logic                      s1_valid;
  logic [CW-1:0]             s1_c;
  logic [gb3_pkg::ROW_W-1:0] s1_r;
  logic                      s1_lc;
  logic                      s1_lr;
  logic [PW-1:0]             s1_pix;
  logic                      s1_fwd;
  logic [PW-1:0]             s1_fwd_top;
  logic [PW-1:0]             s1_fwd_mid;

  // stage 2: weighted sum ready for the divide
  logic                         s2_valid;
  logic [gb3_pkg::COL_FW-1:0]   s2_col;
  logic [gb3_pkg::ROW_W-1:0]    s2_row;
  logic [gb3_pkg::NRES-1:0]     s2_emit;
  logic                         s2_filt;
  logic [gb3_pkg::NUM_W-1:0]    s2_num;
  logic [PW-1:0]                s2_w4;
  logic [PW-1:0]                s2_mid;
  logic [PW-1:0]                s2_w5;
  logic [PW-1:0]                s2_pix;

  logic [PW-1:0] win [6];

  logic                      in_ready, accept, s1_adv, s2_ready;
  logic [LW-1:0]             w_ext, w_eff;
  logic [gb3_pkg::ROW_W-1:0] h_eff;
  logic [CW-1:0]             c_new;
  logic [gb3_pkg::ROW_W-1:0] r_new;
  logic                      lc_new, lr_new;
  logic [PW-1:0]             prev_q, prev2_q, mid_eff, top_eff;
  logic [gb3_pkg::NRES-1:0]  emit1;
  logic                      filt1;
  logic [PW+1:0]             edge_sum, corner_sum;
  logic [gb3_pkg::NUM_W-1:0] num1;
  logic [gb3_pkg::PROD_W-1:0] prod;
  logic [PW-1:0]             quot;

  // handshake through the two stages
  assign push        = s2_valid && !full;
  assign s2_ready    = !s2_valid || !full;
  assign s1_adv      = s1_valid && s2_ready;
  assign in_ready    = !s1_valid || s1_adv;
  assign accept      = pixel_valid && in_ready;
  assign pixel_stall = !in_ready;

  // effective image size
  assign w_ext = LW'(cfg.width);
  assign w_eff = (w_ext == '0) ? LW'(1) : ((w_ext > MAXW) ? MAXW : w_ext);
  assign h_eff = (cfg.height == '0) ? gb3_pkg::ROW_W'(1) : cfg.height;

  // position of the pixel being taken
  assign c_new  = frame_start ? '0 : col_count;
  assign r_new  = frame_start ? '0 : row_count;
  assign lc_new = LW'(c_new) >= (w_eff - LW'(1));
  assign lr_new = r_new >= (h_eff - gb3_pkg::ROW_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (lc_new) begin
        col_count <= '0;
        row_count <= lr_new ? '0 : (r_new + gb3_pkg::ROW_W'(1));
      end else begin
        col_count <= c_new + CW'(1);
        row_count <= r_new;
      end
    end
  end

  // line stores: read when a pixel is taken, written when it leaves stage 1
  gb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_prev (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_c),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (c_new),
    .rdata (prev_q)
  );

  gb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_prev2 (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_c),
    .wdata (mid_eff),
    .re    (accept),
    .raddr (c_new),
    .rdata (prev2_q)
  );

  // bypass when the read hits the column being written in the same cycle
  assign mid_eff = s1_fwd ? s1_fwd_mid : prev_q;
  assign top_eff = s1_fwd ? s1_fwd_top : prev2_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c       <= c_new;
      s1_r       <= r_new;
      s1_lc      <= lc_new;
      s1_lr      <= lr_new;
      s1_pix     <= pixel;
      s1_fwd     <= s1_adv && (s1_c == c_new);
      s1_fwd_top <= mid_eff;
      s1_fwd_mid <= s1_pix;
    end
  end

  // which results this pixel causes
  always_comb begin
    emit1 = '0;
    emit1[gb3_pkg::RES_INNER] = (s1_r != '0) && (s1_c != '0);
    emit1[gb3_pkg::RES_RIGHT] = (s1_r != '0) && s1_lc;
    emit1[gb3_pkg::RES_BELOW] = s1_lr && (s1_c != '0);
    emit1[gb3_pkg::RES_LAST]  = s1_lr && s1_lc;
  end

  assign filt1 = (s1_r > gb3_pkg::ROW_W'(1)) && (s1_c > CW'(1));

  // 16*centre + 4*edges + corners + 18
  assign edge_sum   = (PW+2)'(win[1]) + (PW+2)'(win[3]) + (PW+2)'(win[5]) + (PW+2)'(mid_eff);
  assign corner_sum = (PW+2)'(win[0]) + (PW+2)'(win[2]) + (PW+2)'(top_eff) + (PW+2)'(s1_pix);
  assign num1 = (gb3_pkg::NUM_W'(win[4]) << 4) + (gb3_pkg::NUM_W'(edge_sum) << 2)
              + gb3_pkg::NUM_W'(corner_sum) + gb3_pkg::ROUND_BIAS;

  // window: columns c-2 and c-1 of rows r-2, r-1, r
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_eff;
      win[4] <= mid_eff;
      win[5] <= s1_pix;
    end
  end

  // stage 2 register; pixels with no result are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && (emit1 != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_col  <= gb3_pkg::COL_FW'(s1_c);
      s2_row  <= s1_r;
      s2_emit <= emit1;
      s2_filt <= filt1;
      s2_num  <= num1;
      s2_w4   <= win[4];
      s2_mid  <= mid_eff;
      s2_w5   <= win[5];
      s2_pix  <= s1_pix;
    end
  end

  // divide by 36: drop two bits, then multiply by the reciprocal of nine
  assign prod = gb3_pkg::PROD_W'(s2_num[gb3_pkg::NUM_W-1:2]) * gb3_pkg::PROD_W'(gb3_pkg::DIV9_M);
  assign quot = prod[gb3_pkg::DIV9_K +: PW];

  always_comb begin
    push_entry.col     = s2_col;
    push_entry.row     = s2_row;
    push_entry.emit    = s2_emit;
    push_entry.v_inner = s2_filt ? quot : s2_w4;
    push_entry.v_right = s2_mid;
    push_entry.v_below = s2_w5;
    push_entry.v_last  = s2_pix;
  end

endmodule

`default_nettype wire

>>> rtl/gb3_queue.sv
// Short queue of classified pixels between the front end and the result sequencer.
// Holds gb3_pkg::entry_t words in a small register ring.
`default_nettype none

module gb3_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire gb3_pkg::entry_t push_entry,
  output logic                 full,
  output logic                 head_valid,
  output gb3_pkg::entry_t      head,
  input  wire logic            pop
);

  localparam int PTW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  gb3_pkg::entry_t mem [DEPTH];
  logic [PTW-1:0]  wr_ptr, rd_ptr;
  logic [CNW-1:0]  count;

  assign full       = count == CNW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTW'(DEPTH - 1)) ? '0 : (wr_ptr + PTW'(1));
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTW'(DEPTH - 1)) ? '0 : (rd_ptr + PTW'(1));
      end
      if (push && !pop) begin
        count <= count + CNW'(1);
      end else if (pop && !push) begin
        count <= count - CNW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= CNW'(DEPTH))
    else $error("queue fill level above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> (count != '0))
    else $error("queue popped while empty");

endmodule

`default_nettype wire

>>> rtl/gb3_back.sv
// Result sequencer: walks the results of the head queue entry, one word per cycle while
// result_stall does not hold the output register, into that register. Uses gb3_pkg.
`default_nettype none

module gb3_back #(
  parameter int COL_W = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        head_valid,
  input  wire gb3_pkg::entry_t             head,
  output logic                             pop,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic [COL_W-1:0]                 out_col,
  output logic [gb3_pkg::ROW_W-1:0]        out_row,
  output logic [gb3_pkg::PIX_W-1:0]        out_pixel,
  output logic                             run_last
);

  logic [gb3_pkg::NRES-1:0]   done;
  logic [gb3_pkg::NRES-1:0]   pend, sel, rest;
  logic                       out_load, rest_zero;
  logic [gb3_pkg::COL_FW-1:0] col_sel;
  logic [gb3_pkg::ROW_W-1:0]  row_sel;
  logic [gb3_pkg::PIX_W-1:0]  val_sel;

  assign out_load  = head_valid && (!result_valid || !result_stall);
  assign pend      = head.emit & ~done;
  assign rest      = pend & ~sel;
  assign rest_zero = rest == '0;
  assign pop       = out_load && rest_zero;

  // first pending result of the head entry
  always_comb begin
    sel = '0;
    priority if (pend[gb3_pkg::RES_INNER]) begin
      sel[gb3_pkg::RES_INNER] = 1'b1;
      col_sel = head.col - gb3_pkg::COL_FW'(1);
      row_sel = head.row - gb3_pkg::ROW_W'(1);
      val_sel = head.v_inner;
    end else if (pend[gb3_pkg::RES_RIGHT]) begin
      sel[gb3_pkg::RES_RIGHT] = 1'b1;
      col_sel = head.col;
      row_sel = head.row - gb3_pkg::ROW_W'(1);
      val_sel = head.v_right;
    end else if (pend[gb3_pkg::RES_BELOW]) begin
      sel[gb3_pkg::RES_BELOW] = 1'b1;
      col_sel = head.col - gb3_pkg::COL_FW'(1);
      row_sel = head.row;
      val_sel = head.v_below;
    end else begin
      sel[gb3_pkg::RES_LAST] = 1'b1;
      col_sel = head.col;
      row_sel = head.row;
      val_sel = head.v_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      done         <= '0;
    end else if (out_load) begin
      result_valid <= 1'b1;
      done         <= rest_zero ? '0 : (done | sel);
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_col   <= COL_W'(col_sel);
      out_row   <= row_sel;
      out_pixel <= val_sel;
      run_last  <= rest_zero;
    end
  end

  a_head_pending: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (pend != '0))
    else $error("head entry has no pending result");
  a_partial_keeps_head: assert property (@(posedge clk) disable iff (rst)
    (out_load && !rest_zero) |=> head_valid)
    else $error("entry left the queue before all its results");

endmodule

`default_nettype wire

>>> rtl/gaussian_blur_3x3_stream_core.sv
// Top level of the 3x3 Gaussian blur stream: configuration registers, front end,
// queue and result sequencer. Uses gb3_pkg, gb3_front, gb3_queue, gb3_back.
// Throughput: one pixel per cycle while pixel_stall is low; a pixel in the last column or last row
//   makes up to two results (the final pixel up to four), sent one per cycle while result_stall is low.
// Path: a result reaches result_valid through the line store read, weighted sum, reciprocal
//   multiply into the queue and the output register.
// Reset: synchronous; clears position, window, stage valids, queue and output valid,
//   sets width 2848 and height 4288; line stores keep their contents.
`default_nettype none

module gaussian_blur_3x3_stream_core #(
  parameter int MAX_WIDTH   = 4096,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [gb3_pkg::CFG_IW-1:0]     cfg_index,
  input  wire logic [gb3_pkg::CFG_DW-1:0]     cfg_data,
  input  wire logic                           pixel_valid,
  output logic                                pixel_stall,
  input  wire logic [gb3_pkg::PIX_W-1:0]      pixel,
  input  wire logic                           frame_start,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic [$clog2(MAX_WIDTH)-1:0]        out_col,
  output logic [gb3_pkg::ROW_W-1:0]           out_row,
  output logic [gb3_pkg::PIX_W-1:0]           out_pixel,
  output logic                                run_last
);

  gb3_pkg::cfg_t   cfg;
  gb3_pkg::entry_t push_entry, head;
  logic            push, full, head_valid, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= gb3_pkg::WCFG_W'(2848);
      cfg.height <= gb3_pkg::HCFG_W'(4288);
    end else if (cfg_we) begin
      if (cfg_index == gb3_pkg::REG_WIDTH) begin
        cfg.width <= cfg_data[gb3_pkg::WCFG_W-1:0];
      end else if (cfg_index == gb3_pkg::REG_HEIGHT) begin
        cfg.height <= cfg_data[gb3_pkg::HCFG_W-1:0];
      end
    end
  end

  gb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .frame_start (frame_start),
    .push        (push),
    .push_entry  (push_entry),
    .full        (full)
  );

  gb3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  gb3_back #(.COL_W($clog2(MAX_WIDTH))) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_pixel    (out_pixel),
    .run_last     (run_last)
  );

endmodule

`default_nettype wire

>>> tb/gaussian_blur_3x3_stream_core_tb.sv
// Self-checking testbench of the 3x3 Gaussian blur stream core: drives pixel words and
// register writes, predicts each result word in a scoreboard class, checks them in order.
// Depends on gb3_pkg and gaussian_blur_3x3_stream_core.

module gaussian_blur_3x3_stream_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX        = 4096;
  localparam int COL_W           = 12;
  localparam int SETTLE_CYCLES   = 8;     // lets the result path settle
  localparam int PRESSURE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;

  // one result word as seen on the output side
  typedef struct {
    logic [COL_W-1:0]          col;
    logic [gb3_pkg::ROW_W-1:0] row;
    logic [gb3_pkg::PIX_W-1:0] value;
    logic                      last;
  } blur_word_t;

  // Scoreboard: tracks line stores, window and position, and holds the pending words
  class blur_scoreboard;
    logic [gb3_pkg::PIX_W-1:0] row_above [LINE_MAX];
    logic [gb3_pkg::PIX_W-1:0] row_above2 [LINE_MAX];
    int unsigned      win [6];
    int unsigned      next_col;
    int unsigned      next_row;
    int unsigned      width_reg;
    int unsigned      height_reg;
    blur_word_t       pending [$];
    int               errors;

    function new();
      foreach (row_above[i]) begin
        row_above[i]  = '0;
        row_above2[i] = '0;
      end
      foreach (win[i]) win[i] = 0;
      next_col   = 0;
      next_row   = 0;
      width_reg  = 2848;
      height_reg = 4288;
      errors     = 0;
    endfunction

    function void set_reg(logic [gb3_pkg::CFG_IW-1:0] idx, logic [gb3_pkg::CFG_DW-1:0] data);
      if (idx == gb3_pkg::REG_WIDTH) begin
        width_reg = data[gb3_pkg::WCFG_W-1:0];
      end else if (idx == gb3_pkg::REG_HEIGHT) begin
        height_reg = data[gb3_pkg::HCFG_W-1:0];
      end
    endfunction

    function blur_word_t make_word(int unsigned col, int unsigned row, int unsigned value);
      blur_word_t word;
      word.col   = col[COL_W-1:0];
      word.row   = row[gb3_pkg::ROW_W-1:0];
      word.value = value[gb3_pkg::PIX_W-1:0];
      word.last  = 1'b0;
      return word;
    endfunction

    // accepted pixel: work out the words it releases, in output order
    function void note_pixel(logic [gb3_pkg::PIX_W-1:0] pix, logic first);
      int unsigned w, h, c, r, top, mid, bot, val, edge_sum, corner_sum;
      bit          at_last_col, at_last_row;
      blur_word_t  made [$];

      w = width_reg;
      if (w == 0) w = 1;
      if (w > LINE_MAX) w = LINE_MAX;
      h = height_reg;
      if (h == 0) h = 1;

      if (first) begin
        next_col = 0;
        next_row = 0;
      end
      c = next_col % LINE_MAX;
      r = next_row & 32'hFFFF;
      at_last_col = (c >= w - 1);
      at_last_row = (r >= h - 1);

      top = row_above2[c];
      mid = row_above[c];
      bot = pix;
      row_above2[c] = mid;
      row_above[c]  = bot;

      // centre of the window: filtered when inside the border, else passed through
      if (r >= 1 && c >= 1) begin
        val = win[4];
        if (c >= 2 && r >= 2) begin
          edge_sum   = win[1] + win[3] + win[5] + mid;
          corner_sum = win[0] + win[2] + top + bot;
          val = (16 * win[4] + 4 * edge_sum + corner_sum + 18) / 36;
        end
        made.push_back(make_word(c - 1, r - 1, val));
      end
      // right border of the row above
      if (r >= 1 && at_last_col) made.push_back(make_word(c, r - 1, mid));
      // bottom border, flushed as the last row arrives
      if (at_last_row && c >= 1) made.push_back(make_word(c - 1, r, win[5]));
      if (at_last_row && at_last_col) made.push_back(make_word(c, r, pix));
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      foreach (made[i]) pending.push_back(made[i]);

      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = bot;

      if (at_last_col) begin
        next_col = 0;
        next_row = at_last_row ? 0 : ((r + 1) & 32'hFFFF);
      end else begin
        next_col = c + 1;
        next_row = r;
      end
    endfunction

    function void flag(string msg);
      errors++;
      $error("%s", msg);
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) flag($sformatf("%s: expected %0d, got %0d", field, want, got));
    endfunction

    function void check_result(blur_word_t got);
      blur_word_t want;
      if (pending.size() == 0) begin
        flag($sformatf("result word with none pending: col %0d row %0d pixel %0d",
                       got.col, got.row, got.value));
        return;
      end
      want = pending.pop_front();
      check_field("out_col", want.col, got.col);
      check_field("out_row", want.row, got.row);
      check_field("out_pixel", want.value, got.value);
      check_field("run_last", want.last, got.last);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [gb3_pkg::CFG_IW-1:0] cfg_index = gb3_pkg::REG_WIDTH;
  logic [gb3_pkg::CFG_DW-1:0] cfg_data = '0;
  logic                       pixel_valid = 1'b0;
  logic                       pixel_stall;
  logic [gb3_pkg::PIX_W-1:0]  pixel = '0;
  logic                       frame_start = 1'b0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [COL_W-1:0]           out_col;
  logic [gb3_pkg::ROW_W-1:0]  out_row;
  logic [gb3_pkg::PIX_W-1:0]  out_pixel;
  logic                       run_last;

  bit                eager_sender = 1'b0;
  bit                pressure_req = 1'b0;
  int                quiet_cycles = 0;
  blur_scoreboard    board = new();

  gaussian_blur_3x3_stream_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .frame_start  (frame_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_pixel    (out_pixel),
    .run_last     (run_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle run lengths: mostly short, now and then long
  function automatic int pick_run();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (eager_sender || $urandom_range(0, 99) < 55) return 0;
    return pick_run();
  endfunction

  function automatic logic [gb3_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return gb3_pkg::PIX_W'($urandom_range(0, 15));
      default: return gb3_pkg::PIX_W'($urandom);
    endcase
  endfunction

  // offer one pixel word at a falling edge; returns at the falling edge after acceptance
  task automatic send_pixel(input logic [gb3_pkg::PIX_W-1:0] value, input logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= value;
    frame_start <= first;
    do @(posedge clk); while (pixel_stall);
    board.note_pixel(value, first);
    @(negedge clk);
  endtask

  // raster stream, frame start on the first word and at random as noise
  task automatic send_frame(input int count, input int noise_pct);
    for (int i = 0; i < count; i++) begin
      send_pixel(rand_pixel(), (i == 0) || ($urandom_range(0, 99) < noise_pct));
    end
  endtask

  // all pending words out, then let the pipe settle
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [gb3_pkg::CFG_DW-1:0] width_word,
                           input logic [gb3_pkg::CFG_DW-1:0] height_word);
    cfg_we    <= 1'b1;
    cfg_index <= gb3_pkg::REG_WIDTH;
    cfg_data  <= width_word;
    @(negedge clk);
    board.set_reg(gb3_pkg::REG_WIDTH, width_word);
    cfg_index <= gb3_pkg::REG_HEIGHT;
    cfg_data  <= height_word;
    @(negedge clk);
    board.set_reg(gb3_pkg::REG_HEIGHT, height_word);
    cfg_we <= 1'b0;
  endtask

  // one random image size, streamed whole (maybe twice) or in part when large
  task automatic random_phase(output int sent);
    int w, h, full, sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) w = $urandom_range(0, 2);
    else if (sel < 80) w = $urandom_range(3, 10);
    else if (sel < 95) w = $urandom_range(11, 40);
    else w = $urandom_range(41, 120);
    sel = $urandom_range(0, 99);
    if (sel < 8) h = $urandom_range(0, 2);
    else if (sel < 90) h = $urandom_range(3, 8);
    else h = $urandom_range(9, 65535);
    full = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
    sent = (full > 100) ? $urandom_range(30, 100) : full * $urandom_range(1, 2);
    eager_sender = ($urandom_range(0, 3) == 0);
    configure({3'($urandom), gb3_pkg::WCFG_W'(w)}, gb3_pkg::HCFG_W'(h));
    send_frame(sent, ($urandom_range(0, 3) == 0) ? 4 : 0);
    eager_sender = 1'b0;
    wait_idle();
  endtask

  // output side stall pattern, plus one long hold on request
  initial begin : result_hold
    int   left;
    logic hold;
    left = 0;
    hold = 1'b0;
    forever begin
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold = 1'b1;
        left = PRESSURE_CYCLES;
      end else if (left == 0) begin
        hold = ($urandom_range(0, 99) < 35);
        left = pick_run();
        if (!hold && $urandom_range(0, 19) == 0) left = $urandom_range(50, 150);
      end
      result_stall <= hold;
      left = left - 1;
      @(negedge clk);
    end
  end

  // check every accepted result word
  always @(posedge clk) begin : result_sink
    blur_word_t got;
    if (!rst && result_valid && !result_stall) begin
      got.col   = out_col;
      got.row   = out_row;
      got.value = out_pixel;
      got.last  = run_last;
      board.check_result(got);
    end
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gaussian_blur_3x3_stream_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int random_sent;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // 3x3 image of full-scale pixels, then a lone bright centre reached by wrap-around
    configure(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) send_pixel('1, i == 0);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? '1 : '0, 1'b0);
    wait_idle();

    // zero width and height act as one: every pixel is a whole image
    configure(16'd0, 16'd0);
    send_pixel(16'h8001, 1'b1);
    send_pixel(16'h7FFE, 1'b0);
    wait_idle();

    // shrink mid image so the next pixel lies past the last column, on the last row
    configure(16'd5, 16'd5);
    for (int i = 0; i < 8; i++) send_pixel(gb3_pkg::PIX_W'(1000 * (i + 1)), i == 0);
    wait_idle();
    configure(16'd3, 16'd2);
    send_pixel(16'h1234, 1'b0);
    wait_idle();

    // long output hold while the input keeps coming: the block must back up
    configure(16'd24, 16'd6);
    eager_sender = 1'b1;
    pressure_req = 1'b1;
    send_frame(144, 0);
    eager_sender = 1'b0;
    wait_idle();

    // words sent so far, then random images up to the budget less the closing streams
    random_sent = 173;
    while (random_sent < 260) begin
      random_phase(n);
      random_sent += n;
    end

    // width word above the limit, single-row image
    configure(16'hFFFF, 16'd0);
    send_frame(40, 0);
    wait_idle();

    // tallest image, first rows only
    configure(16'd3, 16'hFFFF);
    send_frame(30, 0);
    wait_idle();

    if (board.errors == 0) begin
      $display("gaussian_blur_3x3_stream_core_tb OK");
    end else begin
      $display("gaussian_blur_3x3_stream_core_tb NOT OK");
    end
    $finish;
  end

endmodule
